// ----- sv/throughput_stability_detector_unit_assert.svh -----
// ----------------------------------------------------------------------------
// throughput stability detector assertion macros
// shared assertion forms for the checker of the detector
// ----------------------------------------------------------------------------
`ifndef THROUGHPUT_STABILITY_DETECTOR_UNIT_ASSERT_SVH
`define THROUGHPUT_STABILITY_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TSD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsd assertion failed");

// next-cycle implication, disabled during reset
`define TSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsd assertion failed");

`endif

// ----- sv/tsd_pkg.sv -----
// ----------------------------------------------------------------------------
// tsd_pkg
// widths, constants and codes shared by the throughput stability detector
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int TOT_W   = 32;
  localparam int INT_W   = 32;
  localparam int THR_W   = 48;
  localparam int FRAC_W  = 16;
  localparam int DRIFT_W = 16;
  localparam int OUT_W   = 3;
  localparam int MAC_W   = 64;
  localparam int ACC_W   = 128;
  localparam int HALF_W  = 32;

  localparam logic [DRIFT_W-1:0] DRIFT_RESET = 16'd3277;

  // outcome codes of a result item
  typedef enum logic [OUT_W-1:0] {
    OUT_IGNORED  = 3'd0,
    OUT_FILLING  = 3'd1,
    OUT_REJECTED = 3'd2,
    OUT_UNSTABLE = 3'd3,
    OUT_STABLE   = 3'd4
  } outcome_t;

endpackage

// ----- sv/tsd_ram.sv -----
// ----------------------------------------------------------------------------
// tsd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module tsd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/tsd_div.sv -----
// ----------------------------------------------------------------------------
// tsd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tsd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [tsd_pkg::THR_W-1:0] num,
  input  logic [tsd_pkg::INT_W-1:0] den,
  output logic                      busy,
  output logic [tsd_pkg::THR_W-1:0] quot
);

  localparam int CNT_W = $clog2(tsd_pkg::THR_W);

  logic [tsd_pkg::INT_W-1:0] rem;
  logic [tsd_pkg::INT_W-1:0] den_r;
  logic [CNT_W-1:0]          cnt;
  logic [tsd_pkg::INT_W:0]   shifted;
  logic                      fits;

  // trial subtract of the shifted remainder
  always_comb begin
    shifted = {rem, quot[tsd_pkg::THR_W-1]};
    fits    = (shifted >= {1'b0, den_r});
  end

  // dividend shifts out at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= '0;
      quot  <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      if (fits) begin
        rem  <= tsd_pkg::INT_W'(shifted - {1'b0, den_r});
        quot <= {quot[tsd_pkg::THR_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[tsd_pkg::INT_W-1:0];
        quot <= {quot[tsd_pkg::THR_W-2:0], 1'b0};
      end
      if (cnt == CNT_W'(tsd_pkg::THR_W - 1)) begin
        busy <= 1'b0;
      end
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// ----- sv/tsd_mac.sv -----
// ----------------------------------------------------------------------------
// tsd_mac
// shared multiply accumulate unit, 64 by 64 from four 32 by 32 products
// ----------------------------------------------------------------------------
module tsd_mac (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      clear,
  input  logic [tsd_pkg::MAC_W-1:0] a,
  input  logic [tsd_pkg::MAC_W-1:0] b,
  output logic                      idle,
  output logic [tsd_pkg::ACC_W-1:0] acc
);

  localparam int H = tsd_pkg::HALF_W;

  logic [tsd_pkg::MAC_W-1:0] a_r;
  logic [tsd_pkg::MAC_W-1:0] b_r;
  logic [1:0]                step;
  logic                      busy;
  logic [tsd_pkg::MAC_W-1:0] prod;
  logic [1:0]                psh;
  logic                      pvld;
  logic [H-1:0]              a_half;
  logic [H-1:0]              b_half;
  logic [tsd_pkg::ACC_W-1:0] addend;

  assign idle = !busy && !pvld;

  // half selection for the current partial product
  always_comb begin
    a_half = step[1] ? a_r[tsd_pkg::MAC_W-1:H] : a_r[H-1:0];
    b_half = step[0] ? b_r[tsd_pkg::MAC_W-1:H] : b_r[H-1:0];
  end

  // align the registered partial product
  always_comb begin
    case (psh)
      2'd0:    addend = tsd_pkg::ACC_W'(prod);
      2'd1:    addend = tsd_pkg::ACC_W'(prod) << H;
      default: addend = tsd_pkg::ACC_W'(prod) << (2 * H);
    endcase
  end

  // multiply stage then accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pvld <= 1'b0;
      step <= '0;
    end else begin
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        step <= '0;
        busy <= 1'b1;
        if (clear) begin
          acc <= '0;
        end
      end else if (busy) begin
        prod <= a_half * b_half;
        psh  <= 2'(step[1]) + 2'(step[0]);
        step <= step + 1'b1;
        if (step == 2'd3) begin
          busy <= 1'b0;
        end
      end
      pvld <= busy;
      if (pvld) begin
        acc <= acc + addend;
      end
    end
  end

endmodule

// ----- sv/throughput_stability_detector_unit.sv -----
// ----------------------------------------------------------------------------
// throughput_stability_detector_unit
// throughput sampling, outlier rejection and sticky stability detection
// ----------------------------------------------------------------------------
// Each item gives a throughput, (delta << 16) / interval_us in Q32.16, from
// a restoring divider; an item with a zero interval skips the divider. While
// the ring of RING_DEPTH samples fills, an item ends after the division, as
// does an item whose throughput is zero. Once the ring is full, the sequencer
// sums the ring (one ram read a cycle) and then runs squared deviations and
// drift products through one shared 64x64 multiply accumulate unit built
// from four 32x32 products: a ram read and a product for each ring sample,
// then the deviation of the new sample and the two drift products. The drift
// products are skipped when the item is rejected or no older accepted sample
// exists yet. The block takes one item at a time; the result sits in an
// output register and the next item is taken meanwhile. The ring ram needs
// no clearing pass.
// ----------------------------------------------------------------------------
module throughput_stability_detector_unit #(
  parameter int RING_DEPTH = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tsd_pkg::TOT_W-1:0]   committed_total,
  input  logic [tsd_pkg::INT_W-1:0]   interval_us,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tsd_pkg::THR_W-1:0]   throughput,
  output logic [tsd_pkg::OUT_W-1:0]   outcome,
  output logic                        window_enabled,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int D_W   = tsd_pkg::THR_W + IDX_W;
  localparam int LO_W  = tsd_pkg::THR_W + tsd_pkg::DRIFT_W + 1;
  localparam int FAC_W = tsd_pkg::DRIFT_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SUM, S_SPR_RD, S_SPR_MAC, S_SPR_WAIT, S_DEV, S_DEV_WAIT,
    S_LO, S_LO_WAIT, S_HI, S_HI_WAIT, S_OUT
  } state_t;

  state_t                      state;
  logic [tsd_pkg::TOT_W-1:0]   previous_total;
  logic [IDX_W-1:0]            ring_position;
  logic [CNT_W-1:0]            fill_count;
  logic [tsd_pkg::THR_W-1:0]   older_throughput;
  logic [tsd_pkg::THR_W-1:0]   last_throughput;
  logic                        stable_flag;
  logic [tsd_pkg::DRIFT_W-1:0] drift_tolerance;
  logic [tsd_pkg::THR_W-1:0]   sample;
  logic [D_W-1:0]              sum;
  logic [tsd_pkg::ACC_W-1:0]   spread9;
  logic [LO_W-1:0]             lower;
  logic [CNT_W-1:0]            cnt;
  tsd_pkg::outcome_t           result;

  // datapath signals
  logic                        accept;
  logic                        cfg_write;
  logic [tsd_pkg::TOT_W-1:0]   delta;
  logic                        div_start;
  logic                        div_busy;
  logic [tsd_pkg::THR_W-1:0]   div_quot;
  logic                        mac_start;
  logic                        mac_clear;
  logic [tsd_pkg::MAC_W-1:0]   mac_a;
  logic [tsd_pkg::MAC_W-1:0]   mac_b;
  logic                        mac_idle;
  logic [tsd_pkg::ACC_W-1:0]   mac_acc;
  logic                        ram_we;
  logic [tsd_pkg::THR_W-1:0]   ram_rdata;
  logic [D_W-1:0]              nx_ring;
  logic [D_W-1:0]              nx_samp;
  logic [D_W-1:0]              d_ring;
  logic [D_W-1:0]              d_samp;
  logic [FAC_W-1:0]            fac_lo;
  logic [FAC_W-1:0]            fac_hi;
  logic [tsd_pkg::MAC_W-1:0]   p_old;
  logic [tsd_pkg::MAC_W-1:0]   p_last;
  logic                        near_old;
  logic                        near_last;
  logic                        out_free;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign delta     = committed_total - previous_total;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata    = (paddr[2] == 1'b0) ? 32'(drift_tolerance) : 32'd0;

  // deviations from the ring sum, all scaled by the ring depth
  always_comb begin
    nx_ring = D_W'(ram_rdata) * D_W'(RING_DEPTH);
    nx_samp = D_W'(sample) * D_W'(RING_DEPTH);
    d_ring  = (nx_ring > sum) ? nx_ring - sum : sum - nx_ring;
    d_samp  = (nx_samp > sum) ? nx_samp - sum : sum - nx_samp;
  end

  // drift bounds against the two previous accepted samples
  always_comb begin
    fac_lo    = FAC_W'(1 << tsd_pkg::FRAC_W) - FAC_W'(drift_tolerance);
    fac_hi    = FAC_W'(1 << tsd_pkg::FRAC_W) + FAC_W'(drift_tolerance);
    p_old     = tsd_pkg::MAC_W'(older_throughput) << tsd_pkg::FRAC_W;
    p_last    = tsd_pkg::MAC_W'(last_throughput) << tsd_pkg::FRAC_W;
    near_old  = (mac_acc > tsd_pkg::ACC_W'(p_old)) && (LO_W'(p_old) > lower);
    near_last = (mac_acc > tsd_pkg::ACC_W'(p_last)) && (LO_W'(p_last) > lower);
  end

  // unit control from the sequencer state
  always_comb begin
    div_start = 1'b0;
    mac_start = 1'b0;
    mac_clear = 1'b0;
    mac_a     = '0;
    mac_b     = '0;
    ram_we    = 1'b0;
    unique case (state)
      S_IDLE: begin
        div_start = accept && (interval_us != '0);
      end
      S_DIV: begin
        ram_we = !div_busy && (div_quot != '0);
      end
      S_SPR_MAC: begin
        mac_start = 1'b1;
        mac_clear = (cnt == '0);
        mac_a     = tsd_pkg::MAC_W'(d_ring);
        mac_b     = (tsd_pkg::MAC_W'(d_ring) << 3) + tsd_pkg::MAC_W'(d_ring);
      end
      S_DEV: begin
        mac_start = 1'b1;
        mac_clear = 1'b1;
        mac_a     = tsd_pkg::MAC_W'(d_samp);
        mac_b     = tsd_pkg::MAC_W'(d_samp) * tsd_pkg::MAC_W'(RING_DEPTH - 1);
      end
      S_LO: begin
        mac_start = 1'b1;
        mac_clear = 1'b1;
        mac_a     = tsd_pkg::MAC_W'(sample);
        mac_b     = tsd_pkg::MAC_W'(fac_lo);
      end
      S_HI: begin
        mac_start = 1'b1;
        mac_clear = 1'b1;
        mac_a     = tsd_pkg::MAC_W'(sample);
        mac_b     = tsd_pkg::MAC_W'(fac_hi);
      end
      default: begin
      end
    endcase
  end

  // sequencer, state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      previous_total   <= '0;
      ring_position    <= '0;
      fill_count       <= '0;
      older_throughput <= '0;
      last_throughput  <= '0;
      stable_flag      <= 1'b0;
      drift_tolerance  <= tsd_pkg::DRIFT_RESET;
      out_valid        <= 1'b0;
      cnt              <= '0;
    end else begin
      if (cfg_write) begin
        drift_tolerance <= pwdata[tsd_pkg::DRIFT_W-1:0];
      end
      // a taken result item leaves unless a new one replaces it
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            previous_total <= committed_total;
            if (interval_us == '0) begin
              sample <= '0;
              result <= tsd_pkg::OUT_IGNORED;
              state  <= S_OUT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            sample <= div_quot;
            if (div_quot == '0) begin
              result <= tsd_pkg::OUT_IGNORED;
              state  <= S_OUT;
            end else begin
              ring_position <= (ring_position == IDX_W'(RING_DEPTH - 1)) ?
                               '0 : ring_position + 1'b1;
              if (fill_count < CNT_W'(RING_DEPTH)) begin
                fill_count <= fill_count + 1'b1;
              end
              if (fill_count < CNT_W'(RING_DEPTH - 1)) begin
                result <= tsd_pkg::OUT_FILLING;
                state  <= S_OUT;
              end else begin
                cnt   <= '0;
                sum   <= '0;
                state <= S_SUM;
              end
            end
          end
        end
        S_SUM: begin
          if (cnt != '0) begin
            sum <= sum + D_W'(ram_rdata);
          end
          if (cnt == CNT_W'(RING_DEPTH)) begin
            cnt   <= '0;
            state <= S_SPR_RD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SPR_RD: begin
          state <= S_SPR_MAC;
        end
        S_SPR_MAC: begin
          state <= S_SPR_WAIT;
        end
        S_SPR_WAIT: begin
          if (mac_idle) begin
            if (cnt == CNT_W'(RING_DEPTH - 1)) begin
              spread9 <= mac_acc;
              state   <= S_DEV;
            end else begin
              cnt   <= cnt + 1'b1;
              state <= S_SPR_RD;
            end
          end
        end
        S_DEV: begin
          state <= S_DEV_WAIT;
        end
        S_DEV_WAIT: begin
          if (mac_idle) begin
            if (mac_acc > spread9) begin
              result <= tsd_pkg::OUT_REJECTED;
              state  <= S_OUT;
            end else if (older_throughput != '0) begin
              state <= S_LO;
            end else begin
              older_throughput <= last_throughput;
              last_throughput  <= sample;
              result <= stable_flag ? tsd_pkg::OUT_STABLE : tsd_pkg::OUT_UNSTABLE;
              state  <= S_OUT;
            end
          end
        end
        S_LO: begin
          state <= S_LO_WAIT;
        end
        S_LO_WAIT: begin
          if (mac_idle) begin
            lower <= mac_acc[LO_W-1:0];
            state <= S_HI;
          end
        end
        S_HI: begin
          state <= S_HI_WAIT;
        end
        S_HI_WAIT: begin
          if (mac_idle) begin
            older_throughput <= last_throughput;
            last_throughput  <= sample;
            if (near_old && near_last) begin
              stable_flag <= 1'b1;
              result      <= tsd_pkg::OUT_STABLE;
            end else begin
              result <= stable_flag ? tsd_pkg::OUT_STABLE : tsd_pkg::OUT_UNSTABLE;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            throughput     <= sample;
            outcome        <= result;
            window_enabled <= stable_flag;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ring of accepted samples
  tsd_ram #(
    .WIDTH (tsd_pkg::THR_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ring_position),
    .wdata (div_quot),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // throughput divider
  tsd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({delta, tsd_pkg::FRAC_W'(0)}),
    .den   (interval_us),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  // shared multiply accumulate unit
  tsd_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .clear (mac_clear),
    .a     (mac_a),
    .b     (mac_b),
    .idle  (mac_idle),
    .acc   (mac_acc)
  );

endmodule

// ----- sv/tsd_checker.sv -----
// ----------------------------------------------------------------------------
// tsd_checker
// port level checks of the throughput stability detector
// ----------------------------------------------------------------------------
`include "throughput_stability_detector_unit_assert.svh"

module tsd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [tsd_pkg::THR_W-1:0] throughput,
  input logic [tsd_pkg::OUT_W-1:0] outcome,
  input logic                      window_enabled
);

  // an accepted item keeps the block busy in the next cycle
  `TSD_ASSERT_NEXT(a_busy_after_item, clk, rst, in_valid && !in_stall, in_stall)

  // the stable flag never clears
  `TSD_ASSERT_NEXT(a_flag_sticky, clk, rst, window_enabled, window_enabled)

  // stable and unstable outcomes agree with the flag
  `TSD_ASSERT_SAME(a_outcome_flag, clk, rst,
    out_valid && (outcome == tsd_pkg::OUT_STABLE || outcome == tsd_pkg::OUT_UNSTABLE),
    window_enabled == (outcome == tsd_pkg::OUT_STABLE))

  // only a zero throughput is ignored
  `TSD_ASSERT_SAME(a_zero_ignored, clk, rst, out_valid,
    (throughput == '0) == (outcome == tsd_pkg::OUT_IGNORED))

  // a stalled result item holds
  `TSD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(throughput) && $stable(outcome))

endmodule

bind throughput_stability_detector_unit tsd_checker u_tsd_checker (.*);
